// ===== hdl/icsp_pkg.sv =====
// ---------------------------------------------------------------------------
// icsp_pkg: shared types and constants of the chunk stream parser
// Event codes, parser phases, sequencer states, the event record and the
// name character test used by the header classifier.
// ---------------------------------------------------------------------------
package icsp_pkg;

   // Result event codes.
   typedef enum logic [2:0] {
      EV_START = 3'd0,
      EV_DATA  = 3'd1,
      EV_END   = 3'd2,
      EV_BAD   = 3'd3,
      EV_DEEP  = 3'd4
   } event_kind_type;

   // Byte parsing phase.
   typedef enum logic [1:0] {
      PH_HDR  = 2'd0,
      PH_LONG = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      S_IDLE,
      S_PROC,
      S_PUSH,
      S_PUSH2,
      S_DUMP,
      S_CAS_RD,
      S_CAS_CHK,
      S_FINISH
   } state_type;

   // One result event without its last flag.
   typedef struct packed {
      event_kind_type kind;
      logic [63:0]    name;
      logic [3:0]     len;
      logic [31:0]    size;
      logic [7:0]     data;
      logic [4:0]     level;
   } event_type;

   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [3:0] HDR_LEN      = 4'd8;
   localparam logic [3:0] LONG_HDR_LEN = 4'd12;
   localparam logic [3:0] NAME_SHORT   = 4'd4;
   localparam logic [3:0] NAME_LONG    = 4'd8;
   localparam logic [4:0] RESULT_CAP   = 5'd24;

   // Characters allowed in a chunk name.
   function automatic logic is_name_char(input logic [7:0] c);
      return (c >= CH_A && c <= CH_Z) || (c >= CH_0 && c <= CH_9) || (c == CH_SPACE);
   endfunction

endpackage

// ===== hdl/icsp_stack_ram.sv =====
// ---------------------------------------------------------------------------
// icsp_stack_ram: stack memory of remaining chunk bytes
// One write port and one read port; read data is registered, so it shows
// in the cycle after the read is issued.
// ---------------------------------------------------------------------------
module icsp_stack_ram #(
   parameter  int DEPTH  = 16,
   parameter  int WIDTH  = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/iff_chunk_stream_parser.sv =====
// ---------------------------------------------------------------------------
// iff_chunk_stream_parser: streaming parser of nested FORM chunk files
// Tracks open chunks in a stack memory and emits start, data, end and
// error events as the file bytes arrive.
// ---------------------------------------------------------------------------
// Usage:
// The req_ channel carries one file byte per item. The rsp_ channel returns
// the events that byte causes, one per item; rsp_last_event marks the final
// event of a byte, and a byte that only fills the header buffer gives none.
// Flow: a byte is accepted, processed in the next cycle (S_PROC), and
// the next byte can be taken in S_FINISH. A chunk start passes through
// S_PUSH, which charges the parent if there is one, and S_PUSH2, which
// writes the new entry, as both go through the single stack write port; a
// dump of 8 buffered data bytes sends them one by one from S_DUMP, and
// every chunk closed in a cascade takes a registered stack read, then a
// compare; the cascade ends by reading and checking the level that stays
// open, if any. Events are staged in a hold register, so the last flag is
// known when the event is sent. When the receiver stalls, the sequencer
// waits at its next event and req_stall stays high. After a bad header or
// too deep nesting the block keeps accepting bytes and drops them until
// reset. Reset is synchronous and clears all control state; the stack
// memory needs no clearing, since every entry is written before it is read.
// ---------------------------------------------------------------------------
module iff_chunk_stream_parser #(
   parameter int MAX_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_byte_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output icsp_pkg::event_kind_type rsp_event_kind,
   output logic [63:0]              rsp_node_name,
   output logic [3:0]               rsp_name_length,
   output logic [31:0]              rsp_node_size,
   output logic [7:0]               rsp_data_value,
   output logic [4:0]               rsp_nest_level,
   output logic                     rsp_last_event
);

   import icsp_pkg::*;

   localparam int LEVEL_W = $clog2(MAX_DEPTH + 1);
   localparam int ADDR_W  = $clog2(MAX_DEPTH);

   // Control and payload registers.
   state_type          state_ff, state_in;
   logic [7:0]         byte_ff, byte_in;
   logic [3:0]         hc_ff, hc_in;
   phase_type          phase_ff, phase_in;
   logic [31:0]        pd_ff, pd_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               err_ff, err_in;
   logic [7:0]         buf_ff [12];
   logic [7:0]         buf_in [12];
   logic [31:0]        size_ff, size_in;
   logic [3:0]         len_ff, len_in;
   logic [2:0]         kidx_ff, kidx_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               hold_v_ff, hold_v_in;
   event_type          hold_ff, hold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   event_type          out_ff, out_in;
   logic               out_last_ff, out_last_in;

   // Stack memory port.
   logic               ram_we, ram_re;
   logic [ADDR_W-1:0]  ram_wa, ram_ra;
   logic [31:0]        ram_wd, top;

   // Decode of the current byte.
   logic [LEVEL_W-1:0] level_m1, level_p1;
   logic [LEVEL_W+4:0] level_ext, level_p1_ext;
   logic [4:0]         lvl5, lvl5_p1;
   logic               lvl_nz, at_max;
   logic [3:0]         hc2, hc_new;
   logic [7:0]         nb [12];
   logic               cls_data, cls_short, found, form_ok;
   logic               is_data_ph, is_tail, hdr_full, is_bad, proc_emits;
   logic [31:0]        pd_dec, tail_pd, dump_pd, be32_4, be32_8;
   logic [33:0]        charge, parent_diff;
   logic [31:0]        parent_new;
   logic [63:0]        push_name;

   // Handshake helpers.
   logic               out_free, emit_ok, can_accept, accept;
   logic               new_ev_v;
   event_type          new_ev;

   icsp_stack_ram #(
      .DEPTH (MAX_DEPTH),
      .WIDTH (32)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (top)
   );

   // Level arithmetic and the 5-bit view of the depth.
   assign level_m1     = level_ff - LEVEL_W'(1);
   assign level_p1     = level_ff + LEVEL_W'(1);
   assign level_ext    = {5'b0, level_ff};
   assign level_p1_ext = {5'b0, level_p1};
   assign lvl5         = level_ext[4:0];
   assign lvl5_p1      = level_p1_ext[4:0];
   assign lvl_nz       = (level_ff != '0);
   assign at_max       = (level_ff >= LEVEL_W'(MAX_DEPTH));

   // Output handshake and event slot availability.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_ok    = (cnt_ff >= RESULT_CAP) || !hold_v_ff || out_free;
   assign can_accept = (state_ff == S_IDLE) ||
                       ((state_ff == S_FINISH) && (!hold_v_ff || out_free));
   assign req_stall  = !can_accept;
   assign accept     = req_valid && can_accept;

   // Header buffer view with the current byte written in.
   always_comb begin
      hc2    = (hc_ff >= LONG_HDR_LEN) ? 4'd0 : hc_ff;
      hc_new = hc2 + 4'd1;
      for (int i = 0; i < 12; i++) begin
         nb[i] = (4'(i) == hc2) ? byte_ff : buf_ff[i];
      end
   end

   // Name classification: position of the first non-name character.
   always_comb begin
      cls_data  = 1'b0;
      cls_short = 1'b0;
      found     = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!found && !is_name_char(nb[i])) begin
            found = 1'b1;
            if (i < 4) begin
               cls_data = 1'b1;
            end else begin
               cls_short = 1'b1;
            end
         end
      end
   end

   // Case decode of the byte in process.
   always_comb begin
      form_ok    = (nb[0] == CH_F) && (nb[1] == CH_O) && (nb[2] == CH_R) && (nb[3] == CH_M);
      be32_4     = {nb[4], nb[5], nb[6], nb[7]};
      be32_8     = {nb[8], nb[9], nb[10], nb[11]};
      is_data_ph = (phase_ff == PH_DATA);
      is_tail    = (phase_ff == PH_HDR) && (hc_ff == 4'd0) && lvl_nz && (top < 32'd8);
      hdr_full   = (phase_ff == PH_HDR) && (hc_new == HDR_LEN);
      is_bad     = !is_data_ph && !is_tail && hdr_full && !lvl_nz && !form_ok;
      proc_emits = is_data_ph || is_tail || is_bad;
      pd_dec     = (pd_ff != 32'd0) ? pd_ff - 32'd1 : 32'd0;
      tail_pd    = (top != 32'd0) ? top - 32'd1 : 32'd0;
      dump_pd    = (top >= 32'd8) ? top - 32'd8 : 32'd0;
   end

   // Parent charge for a new child: header plus size, clamped at zero.
   always_comb begin
      charge      = {2'b0, size_ff} + {30'b0, len_ff} + 34'd4;
      parent_diff = {2'b0, top} - charge;
      parent_new  = ({2'b0, top} > charge) ? parent_diff[31:0] : 32'd0;
      if (len_ff == NAME_LONG) begin
         push_name = {buf_ff[0], buf_ff[1], buf_ff[2], buf_ff[3],
                      buf_ff[4], buf_ff[5], buf_ff[6], buf_ff[7]};
      end else begin
         push_name = {buf_ff[0], buf_ff[1], buf_ff[2], buf_ff[3], 32'b0};
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE, S_FINISH: begin
            if (accept && !err_ff) begin
               state_in = S_PROC;
            end else if (can_accept) begin
               state_in = S_IDLE;
            end
         end
         S_PROC: begin
            if (proc_emits && !emit_ok) begin
               state_in = S_PROC;
            end else if (is_data_ph) begin
               state_in = (pd_dec == 32'd0) ? S_CAS_RD : S_FINISH;
            end else if (is_tail) begin
               state_in = (tail_pd == 32'd0) ? S_CAS_RD : S_FINISH;
            end else if (phase_ff == PH_LONG) begin
               state_in = (hc_new == LONG_HDR_LEN) ? S_PUSH : S_FINISH;
            end else if (hdr_full) begin
               if (!lvl_nz) begin
                  state_in = form_ok ? S_PUSH : S_FINISH;
               end else if (cls_data) begin
                  state_in = S_DUMP;
               end else if (cls_short) begin
                  state_in = S_PUSH;
               end else begin
                  state_in = S_FINISH;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_PUSH: begin
            if (!at_max) begin
               state_in = S_PUSH2;
            end else if (emit_ok) begin
               state_in = S_FINISH;
            end
         end
         S_PUSH2: begin
            if (emit_ok) begin
               state_in = (size_ff == 32'd0) ? S_CAS_RD : S_FINISH;
            end
         end
         S_DUMP: begin
            if (emit_ok && kidx_ff == 3'd7) begin
               state_in = (pd_ff == 32'd0) ? S_CAS_RD : S_FINISH;
            end
         end
         S_CAS_RD: begin
            state_in = lvl_nz ? S_CAS_CHK : S_FINISH;
         end
         S_CAS_CHK: begin
            if (top != 32'd0) begin
               state_in = S_FINISH;
            end else if (emit_ok) begin
               state_in = S_CAS_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, stack access and event generation.
   always_comb begin
      byte_in  = byte_ff;
      hc_in    = hc_ff;
      phase_in = phase_ff;
      pd_in    = pd_ff;
      level_in = level_ff;
      err_in   = err_ff;
      buf_in   = buf_ff;
      size_in  = size_ff;
      len_in   = len_ff;
      kidx_in  = kidx_ff;
      ram_we   = 1'b0;
      ram_wa   = level_m1[ADDR_W-1:0];
      ram_wd   = 32'd0;
      ram_re   = 1'b0;
      ram_ra   = level_m1[ADDR_W-1:0];
      new_ev_v = 1'b0;
      new_ev   = '0;
      unique case (state_ff)
         S_IDLE, S_FINISH: begin
            // Take the next byte and fetch the top of the stack.
            if (accept) begin
               byte_in = req_byte_in;
               ram_re  = lvl_nz && !err_ff;
            end
         end
         S_PROC: begin
            if (!(proc_emits && !emit_ok)) begin
               if (is_data_ph) begin
                  new_ev_v = 1'b1;
                  new_ev.kind  = EV_DATA;
                  new_ev.data  = byte_ff;
                  new_ev.level = lvl5;
                  pd_in = pd_dec;
                  if (pd_dec == 32'd0) begin
                     phase_in = PH_HDR;
                  end
               end else if (is_tail) begin
                  // Fewer than a header's bytes left: the rest is raw data.
                  ram_we   = 1'b1;
                  new_ev_v = 1'b1;
                  new_ev.kind  = EV_DATA;
                  new_ev.data  = byte_ff;
                  new_ev.level = lvl5;
                  pd_in = tail_pd;
                  if (tail_pd != 32'd0) begin
                     phase_in = PH_DATA;
                  end
               end else begin
                  buf_in = nb;
                  hc_in  = hc_new;
                  if (phase_ff == PH_LONG) begin
                     if (hc_new == LONG_HDR_LEN) begin
                        hc_in    = 4'd0;
                        phase_in = PH_HDR;
                        len_in   = NAME_LONG;
                        size_in  = be32_8;
                     end
                  end else if (hdr_full) begin
                     if (!lvl_nz) begin
                        hc_in   = 4'd0;
                        len_in  = NAME_SHORT;
                        size_in = be32_4;
                        if (!form_ok) begin
                           new_ev_v    = 1'b1;
                           new_ev.kind = EV_BAD;
                           err_in      = 1'b1;
                        end
                     end else if (cls_data) begin
                        hc_in   = 4'd0;
                        ram_we  = 1'b1;
                        pd_in   = dump_pd;
                        kidx_in = 3'd0;
                        if (dump_pd != 32'd0) begin
                           phase_in = PH_DATA;
                        end
                     end else if (cls_short) begin
                        hc_in   = 4'd0;
                        len_in  = NAME_SHORT;
                        size_in = be32_4;
                     end else begin
                        phase_in = PH_LONG;
                     end
                  end
               end
            end
         end
         S_PUSH: begin
            if (at_max) begin
               if (emit_ok) begin
                  new_ev_v     = 1'b1;
                  new_ev.kind  = EV_DEEP;
                  new_ev.level = lvl5;
                  err_in       = 1'b1;
               end
            end else begin
               // Charge the parent for the new child.
               ram_we = lvl_nz;
               ram_wd = parent_new;
            end
         end
         S_PUSH2: begin
            if (emit_ok) begin
               ram_we   = 1'b1;
               ram_wa   = level_ff[ADDR_W-1:0];
               ram_wd   = size_ff;
               level_in = level_p1;
               new_ev_v = 1'b1;
               new_ev.kind  = EV_START;
               new_ev.name  = push_name;
               new_ev.len   = len_ff;
               new_ev.size  = size_ff;
               new_ev.level = lvl5_p1;
            end
         end
         S_DUMP: begin
            if (emit_ok) begin
               new_ev_v = 1'b1;
               new_ev.kind  = EV_DATA;
               new_ev.data  = buf_ff[kidx_ff];
               new_ev.level = lvl5;
               kidx_in = kidx_ff + 3'd1;
            end
         end
         S_CAS_RD: begin
            ram_re = lvl_nz;
         end
         S_CAS_CHK: begin
            // An emptied level closes and the parent is checked next.
            if (top == 32'd0 && emit_ok) begin
               new_ev_v     = 1'b1;
               new_ev.kind  = EV_END;
               new_ev.level = lvl5;
               level_in     = level_m1;
            end
         end
         default: begin
            new_ev_v = 1'b0;
         end
      endcase
   end

   // Hold register and output register.
   always_comb begin
      cnt_in       = cnt_ff;
      hold_v_in    = hold_v_ff;
      hold_in      = hold_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (new_ev_v && cnt_ff < RESULT_CAP) begin
         if (hold_v_ff) begin
            out_in       = hold_ff;
            out_last_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         hold_in   = new_ev;
         hold_v_in = 1'b1;
         cnt_in    = cnt_ff + 5'd1;
      end else if (state_ff == S_FINISH && hold_v_ff && out_free) begin
         out_in       = hold_ff;
         out_last_in  = 1'b1;
         rsp_valid_in = 1'b1;
         hold_v_in    = 1'b0;
      end
      if (accept) begin
         cnt_in = 5'd0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hc_ff        <= 4'd0;
         phase_ff     <= PH_HDR;
         pd_ff        <= 32'd0;
         level_ff     <= '0;
         err_ff       <= 1'b0;
         cnt_ff       <= 5'd0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kidx_ff      <= 3'd0;
      end else begin
         state_ff     <= state_in;
         hc_ff        <= hc_in;
         phase_ff     <= phase_in;
         pd_ff        <= pd_in;
         level_ff     <= level_in;
         err_ff       <= err_in;
         cnt_ff       <= cnt_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
         kidx_ff      <= kidx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      buf_ff      <= buf_in;
      size_ff     <= size_in;
      len_ff      <= len_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = out_ff.kind;
   assign rsp_node_name   = out_ff.name;
   assign rsp_name_length = out_ff.len;
   assign rsp_node_size   = out_ff.size;
   assign rsp_data_value  = out_ff.data;
   assign rsp_nest_level  = out_ff.level;
   assign rsp_last_event  = out_last_ff;

endmodule

// ===== hdl/icsp_checker.sv =====
// ---------------------------------------------------------------------------
// icsp_checker: port level checks of the chunk stream parser
// Watches the result channel for handshake stability and event field
// consistency; attached to the top level by a bind.
// ---------------------------------------------------------------------------
module icsp_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input icsp_pkg::event_kind_type rsp_event_kind,
   input logic [63:0]              rsp_node_name,
   input logic [3:0]               rsp_name_length,
   input logic [31:0]              rsp_node_size,
   input logic [7:0]               rsp_data_value,
   input logic [4:0]               rsp_nest_level,
   input logic                     rsp_last_event
);

   import icsp_pkg::*;

   // A stalled item stays put.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind) &&
      $stable(rsp_data_value) && $stable(rsp_node_size) && $stable(rsp_last_event))
      else $error("result item changed while stalled");

   // A node start carries a valid name length and a nonzero depth.
   a_start_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_START |->
      (rsp_name_length == NAME_SHORT || rsp_name_length == NAME_LONG) &&
      rsp_nest_level != 5'd0)
      else $error("node start with bad length or depth");

   // Only a node start carries a name and size.
   a_other_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_START |->
      rsp_node_name == 64'd0 && rsp_name_length == 4'd0 && rsp_node_size == 32'd0)
      else $error("name or size on a non-start item");

   // A bad format is the only and final item of its byte, at the top level.
   a_bad_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_BAD |-> rsp_last_event && rsp_nest_level == 5'd0)
      else $error("bad format item not final or not at top level");

endmodule

bind iff_chunk_stream_parser icsp_checker u_icsp_checker (.*);

// ===== tb/iff_chunk_stream_parser_tb.sv =====
// ---------------------------------------------------------------------------
// iff_chunk_stream_parser_tb: self-checking bench of the chunk stream parser
// Feeds generated FORM files one byte per item with random gaps and stalls.
// Keeps its own model of the chunk stack and checks every event in order.
// The run closes with deep nesting or a bad header, which halts the block.
// ---------------------------------------------------------------------------
module iff_chunk_stream_parser_tb;
   import icsp_pkg::*;

   localparam int DEPTH_LIMIT = 16;
   localparam int EVENTS_PER_BYTE = 24;

   typedef logic [7:0] byte_list_type[$];

   typedef struct {
      event_type ev;
      logic      last;
   } parse_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_byte_in;
   logic                rsp_valid;
   logic                rsp_stall;
   event_kind_type      rsp_event_kind;
   logic [63:0]         rsp_node_name;
   logic [3:0]          rsp_name_length;
   logic [31:0]         rsp_node_size;
   logic [7:0]          rsp_data_value;
   logic [4:0]          rsp_nest_level;
   logic                rsp_last_event;

   iff_chunk_stream_parser dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_byte_in(req_byte_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_event_kind(rsp_event_kind), .rsp_node_name(rsp_node_name),
      .rsp_name_length(rsp_name_length), .rsp_node_size(rsp_node_size),
      .rsp_data_value(rsp_data_value), .rsp_nest_level(rsp_nest_level),
      .rsp_last_event(rsp_last_event)
   );

   // Bench state.
   byte_list_type    file_bytes;
   parse_result_type expected_events[$];
   bit               failed = 0;
   bit               byte_taken = 0;
   int               send_gap = 0;
   int               stall_left = 0;
   int               hold_left = 0;
   int               bytes_sent = 0;

   // Shadow parser state.
   logic [7:0]      hdr_buf[12];
   int              hdr_count;
   phase_type       phase;
   logic [31:0]     data_left;
   logic [31:0]     remain[DEPTH_LIMIT];
   int              depth;
   bit              halted;
   int              byte_events;

   // Clock.
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // A random idle length, zero most of the time.
   function automatic int idle_draw();
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
   endfunction

   function automatic logic [7:0] name_char_draw();
      int r;
      r = $urandom_range(0, 37);
      if (r < 26) return 8'(8'h41 + r);
      if (r < 36) return 8'(8'h30 + (r - 26));
      return 8'h20;
   endfunction

   function automatic byte_list_type size_bytes(int unsigned n);
      return '{n[31:24], n[23:16], n[15:8], n[7:0]};
   endfunction

   // The characters of a text as a byte list.
   function automatic byte_list_type text_bytes(string s);
      byte_list_type q;
      for (int i = 0; i < s.len(); i++) q = {q, 8'(s[i])};
      return q;
   endfunction

   // One chunk with a short or long name around a random body.
   function automatic byte_list_type make_chunk(int lvl);
      byte_list_type body, hdr;
      int            nlen;
      body = make_body(lvl);
      nlen = ($urandom_range(0, 3) == 0) ? 8 : 4;
      for (int i = 0; i < nlen; i++) hdr = {hdr, name_char_draw()};
      return {hdr, size_bytes(body.size()), body};
   endfunction

   // Child chunks, optionally closed by a run of raw data.
   function automatic byte_list_type make_body(int lvl);
      byte_list_type body, kid;
      int            n, len;
      n = (lvl >= 4) ? 0 : $urandom_range(0, 2);
      for (int k = 0; k < n; k++) begin
         kid = make_chunk(lvl + 1);
         body = {body, kid};
      end
      if ($urandom_range(0, 1)) begin
         len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) body = {body, 8'($urandom_range(0, 255))};
         // A run of eight or more must not look like a chunk name.
         if (len >= 8) body[body.size() - len] = $urandom_range(0, 31);
      end
      return body;
   endfunction

   // Expected events.
   function automatic void emit(event_kind_type kind, logic [63:0] name, logic [3:0] len,
                                logic [31:0] size, logic [7:0] data, int lvl);
      parse_result_type r;
      if (byte_events < EVENTS_PER_BYTE) begin
         r.ev = '{kind: kind, name: name, len: len, size: size, data: data,
                  level: lvl[4:0]};
         r.last = 0;
         expected_events = {expected_events, r};
      end
      byte_events++;
   endfunction

   function automatic void close_empty_levels();
      while (depth > 0 && remain[depth - 1] == 0) begin
         emit(EV_END, 0, 0, 0, 0, depth);
         depth--;
      end
   endfunction

   function automatic bit name_ok(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39) || c == 8'h20;
   endfunction

   function automatic logic [31:0] hdr_word(int at);
      return {hdr_buf[at], hdr_buf[at + 1], hdr_buf[at + 2], hdr_buf[at + 3]};
   endfunction

   function automatic void open_chunk(int nlen, logic [31:0] size);
      logic [63:0] name;
      logic [63:0] charge;
      if (depth >= DEPTH_LIMIT) begin
         emit(EV_DEEP, 0, 0, 0, 0, depth);
         halted = 1;
         return;
      end
      // The parent pays for the header and the payload, never below zero.
      if (depth > 0) begin
         charge = 64'(size) + 64'(nlen) + 64'd4;
         remain[depth - 1] = (64'(remain[depth - 1]) > charge) ?
                             32'(64'(remain[depth - 1]) - charge) : 32'd0;
      end
      name = 0;
      for (int i = 0; i < nlen; i++) name |= 64'(hdr_buf[i]) << (56 - 8 * i);
      remain[depth] = size;
      depth++;
      emit(EV_START, name, 4'(nlen), size, 0, depth);
      if (size == 0) close_empty_levels();
   endfunction

   // Works out every event that one byte causes.
   function automatic void predict_events(logic [7:0] b);
      int          first, cls;
      logic [31:0] r;
      byte_events = 0;
      first = expected_events.size();
      if (halted) return;
      if (phase == PH_DATA) begin
         emit(EV_DATA, 0, 0, 0, b, depth);
         if (data_left > 0) data_left--;
         if (data_left == 0) begin
            phase = PH_HDR;
            close_empty_levels();
         end
      end else if (phase == PH_HDR && hdr_count == 0 && depth > 0 && remain[depth - 1] < 8)
      begin
         // Too little left for a header: the rest is raw data.
         r = remain[depth - 1];
         remain[depth - 1] = 0;
         emit(EV_DATA, 0, 0, 0, b, depth);
         data_left = (r > 0) ? r - 1 : 0;
         if (data_left == 0) close_empty_levels();
         else phase = PH_DATA;
      end else begin
         if (hdr_count >= 12) hdr_count = 0;
         hdr_buf[hdr_count] = b;
         hdr_count++;
         if (phase == PH_LONG) begin
            if (hdr_count == 12) begin
               hdr_count = 0;
               phase = PH_HDR;
               open_chunk(8, hdr_word(8));
            end
         end else if (hdr_count == 8) begin
            if (depth == 0) begin
               hdr_count = 0;
               if (hdr_buf[0] == CH_F && hdr_buf[1] == CH_O && hdr_buf[2] == CH_R &&
                   hdr_buf[3] == CH_M) begin
                  open_chunk(4, hdr_word(4));
               end else begin
                  emit(EV_BAD, 0, 0, 0, 0, 0);
                  halted = 1;
               end
            end else begin
               cls = 8;
               for (int i = 7; i >= 0; i--) if (!name_ok(hdr_buf[i])) cls = (i < 4) ? 0 : 4;
               if (cls == 0) begin
                  // Not a header after all: the buffered bytes are data.
                  r = remain[depth - 1];
                  hdr_count = 0;
                  for (int i = 0; i < 8; i++) emit(EV_DATA, 0, 0, 0, hdr_buf[i], depth);
                  remain[depth - 1] = 0;
                  data_left = (r >= 8) ? r - 8 : 0;
                  if (data_left == 0) close_empty_levels();
                  else phase = PH_DATA;
               end else if (cls == 4) begin
                  hdr_count = 0;
                  open_chunk(4, hdr_word(4));
               end else begin
                  phase = PH_LONG;
               end
            end
         end
      end
      if (expected_events.size() > first)
         expected_events[expected_events.size() - 1].last = 1;
   endfunction

   // Byte sender: holds an offered item until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_byte_in <= 0;
      end else if (!req_valid || byte_taken) begin
         byte_taken = 0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 0;
         end else if (file_bytes.size() > 0) begin
            req_valid <= 1;
            req_byte_in <= file_bytes[0];
         end else begin
            req_valid <= 0;
         end
      end
   end

   // Byte acceptance and prediction.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_events(req_byte_in);
         void'(file_bytes.pop_front());
         byte_taken = 1;
         send_gap = idle_draw();
         bytes_sent++;
         if (bytes_sent == 60) hold_left = 300;
      end
   end

   // Receiver stall, with one long hold-off to back the block up.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // Event checker.
   always @(posedge clock) begin
      parse_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         stall_left = idle_draw();
         if (expected_events.size() == 0) begin
            $error("unexpected event kind %0d", rsp_event_kind);
            failed = 1;
         end else begin
            e = expected_events.pop_front();
            if (rsp_event_kind !== e.ev.kind) begin
               $error("event_kind: expected %0d, got %0d", e.ev.kind, rsp_event_kind);
               failed = 1;
            end
            if (rsp_node_name !== e.ev.name) begin
               $error("node_name: expected %h, got %h", e.ev.name, rsp_node_name);
               failed = 1;
            end
            if (rsp_name_length !== e.ev.len) begin
               $error("name_length: expected %0d, got %0d", e.ev.len, rsp_name_length);
               failed = 1;
            end
            if (rsp_node_size !== e.ev.size) begin
               $error("node_size: expected %0d, got %0d", e.ev.size, rsp_node_size);
               failed = 1;
            end
            if (rsp_data_value !== e.ev.data) begin
               $error("data_value: expected %0d, got %0d", e.ev.data, rsp_data_value);
               failed = 1;
            end
            if (rsp_nest_level !== e.ev.level) begin
               $error("nest_level: expected %0d, got %0d", e.ev.level, rsp_nest_level);
               failed = 1;
            end
            if (rsp_last_event !== e.last) begin
               $error("last_event: expected %0d, got %0d", e.last, rsp_last_event);
               failed = 1;
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      byte_list_type body;
      reset = 1;
      hdr_count = 0;
      phase = PH_HDR;
      data_left = 0;
      depth = 0;
      halted = 0;

      // Empty chunk closing at once, short raw tail with extreme bytes.
      file_bytes = {text_bytes("FORM"), size_bytes(18), text_bytes("AB 1"), size_bytes(0),
                    text_bytes("R 9Z"), size_bytes(2), 8'hFF, 8'h00};
      // Long name whose size overruns its parent.
      file_bytes = {file_bytes, text_bytes("FORM"), size_bytes(8),
                    text_bytes("LONGNAME"), size_bytes(1), 8'h80};

      while (file_bytes.size() < 180) begin
         body = make_body(1);
         file_bytes = {file_bytes, text_bytes("FORM"), size_bytes(body.size()), body};
      end

      // Finish with either nesting past the limit or a bad top header.
      if ($urandom_range(0, 1)) begin
         file_bytes = {file_bytes, text_bytes("FORM"), size_bytes(2000)};
         for (int d = 0; d < DEPTH_LIMIT; d++)
            file_bytes = {file_bytes, text_bytes("DEEP"), size_bytes(1000 - 8 * d)};
      end else begin
         file_bytes = {file_bytes, text_bytes("RIFF"), size_bytes(4)};
      end
      for (int i = 0; i < 6; i++) file_bytes = {file_bytes, 8'($urandom_range(0, 255))};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      while (file_bytes.size() > 0 || req_valid || expected_events.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (expected_events.size() > 0) begin
         $error("%0d expected events never arrived", expected_events.size());
         failed = 1;
      end
      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/icsp_pkg.sv
hdl/icsp_stack_ram.sv
hdl/iff_chunk_stream_parser.sv
hdl/icsp_checker.sv
tb/iff_chunk_stream_parser_tb.sv
